// ----- src/sve_pkg.sv -----
package sve_pkg;

    localparam logic [24:0] Q_ONE  = 25'h100_0000;
    localparam logic [48:0] Q_HALF = 49'h0_0000_0080_0000;
    localparam logic [31:0] GAP_LIMIT = 32'd100;

    localparam logic [1:0] REG_DC_ALPHA   = 2'd0;
    localparam logic [1:0] REG_CUTOFF     = 2'd1;
    localparam logic [1:0] REG_DEF_PERIOD = 2'd2;

    localparam logic [24:0] DC_ALPHA_RST   = 25'd16777;
    localparam logic [24:0] CUTOFF_RST     = 25'd52705;
    localparam logic [6:0]  DEF_PERIOD_RST = 7'd1;

    typedef struct packed {
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic mean_upd;
        logic inc_calc;
        logic integ_upd;
        logic smooth_diff;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- src/sve_ctrl.sv -----
module sve_ctrl
    import sve_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LO1   = 4'd1;
    localparam logic [3:0] ST_HI1   = 4'd2;
    localparam logic [3:0] ST_MEAN  = 4'd3;
    localparam logic [3:0] ST_INC   = 4'd4;
    localparam logic [3:0] ST_INTEG = 4'd5;
    localparam logic [3:0] ST_SDIFF = 4'd6;
    localparam logic [3:0] ST_LO2   = 4'd7;
    localparam logic [3:0] ST_HI2   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LO1;
                end
            end
            ST_LO1: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_HI1;
            end
            ST_HI1: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_MEAN;
            end
            ST_MEAN: begin
                o_cmd.mean_upd = 1'b1;
                n_state        = ST_INC;
            end
            ST_INC: begin
                o_cmd.inc_calc = 1'b1;
                n_state        = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.integ_upd = 1'b1;
                n_state         = ST_SDIFF;
            end
            ST_SDIFF: begin
                o_cmd.smooth_diff = 1'b1;
                n_state           = ST_LO2;
            end
            ST_LO2: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_HI2;
            end
            ST_HI2: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/sve_dpath.sv -----
module sve_dpath
    import sve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data,
    input  logic [63:0] i_req_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [47:0] o_out_data
);

    logic [24:0] r_dc_alpha;
    logic [24:0] r_cutoff;
    logic [6:0]  r_def_period;

    logic [31:0]        r_last_time;
    logic signed [31:0] r_mean;
    logic signed [47:0] r_integ;
    logic signed [47:0] r_smooth;

    logic signed [31:0] r_ax;
    logic [6:0]         r_step;
    logic [24:0]        r_coef;
    logic signed [48:0] r_d;
    logic [24:0]        r_c;
    logic [24:0]        r_lo;
    logic signed [50:0] r_prod;
    logic signed [40:0] r_inc;
    logic [47:0]        r_out;
    logic               r_out_valid;

    logic signed [31:0] w_ax;
    logic [31:0]        w_now;
    logic [31:0]        w_gap;
    logic [6:0]         w_step;
    logic [24:0]        w_alpha;
    logic [48:0]        w_lo_prod;
    logic [48:0]        w_lo_sum;
    logic signed [50:0] w_hi_prod;
    logic [31:0]        w_coef_prod;
    logic signed [32:0] w_acc_diff;
    logic signed [48:0] w_v;
    logic signed [47:0] w_v_sat;
    logic signed [47:0] w_smooth;

    // accel_x in the low word, time_ms in the high word
    assign w_ax  = $signed(i_req_data[31:0]);
    assign w_now = i_req_data[63:32];
    assign w_gap = w_now - r_last_time;
    assign w_step = ((w_gap == '0) || (w_gap > GAP_LIMIT)) ? r_def_period : w_gap[6:0];
    assign w_alpha = (r_dc_alpha > Q_ONE) ? Q_ONE : r_dc_alpha;

    // round(d * c / 2^24) split as d = dh * 2^24 + dl, dl unsigned
    assign w_lo_prod = {25'd0, r_d[23:0]} * {24'd0, r_c};
    assign w_lo_sum  = w_lo_prod + Q_HALF;
    assign w_hi_prod = 51'($signed(r_d[48:24])) * 51'($signed({1'b0, r_c}));

    assign w_coef_prod = {7'd0, r_cutoff} * {25'd0, r_step};

    assign w_acc_diff = {r_ax[31], r_ax} - {r_mean[31], r_mean};

    assign w_v = {r_integ[47], r_integ} + {{8{r_inc[40]}}, r_inc};
    always_comb begin
        if (w_v[48] != w_v[47]) begin
            w_v_sat = w_v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            w_v_sat = w_v[47:0];
        end
    end

    assign w_smooth = r_smooth + r_prod[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_alpha   <= DC_ALPHA_RST;
            r_cutoff     <= CUTOFF_RST;
            r_def_period <= DEF_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DC_ALPHA:   r_dc_alpha   <= i_cfg_data;
                REG_CUTOFF:     r_cutoff     <= i_cfg_data;
                REG_DEF_PERIOD: r_def_period <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_mean      <= '0;
            r_integ     <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last_time <= w_now;
            end
            if (i_cmd.mean_upd) begin
                r_mean <= r_mean + r_prod[31:0];
            end
            if (i_cmd.integ_upd) begin
                r_integ <= w_v_sat;
            end
            if (i_cmd.finish) begin
                r_smooth    <= w_smooth;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ax   <= w_ax;
            r_step <= w_step;
            r_d    <= {{17{w_ax[31]}}, w_ax} - {{17{r_mean[31]}}, r_mean};
            r_c    <= w_alpha;
        end
        if (i_cmd.mul_lo) begin
            r_lo   <= w_lo_sum[48:24];
            r_coef <= (w_coef_prod > {7'd0, Q_ONE}) ? Q_ONE : w_coef_prod[24:0];
        end
        if (i_cmd.mul_hi) begin
            r_prod <= w_hi_prod + $signed({26'd0, r_lo});
        end
        if (i_cmd.inc_calc) begin
            r_inc <= 41'(w_acc_diff) * 41'($signed({1'b0, r_step}));
        end
        if (i_cmd.smooth_diff) begin
            r_d <= {r_integ[47], r_integ} - {r_smooth[47], r_smooth};
            r_c <= r_coef;
        end
        if (i_cmd.finish) begin
            r_out <= w_smooth;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ----- src/sway_velocity_estimator.sv -----
// A request steps through LO1, HI1, MEAN, INC, INTEG, SDIFF, LO2, HI2 and DONE;
// new requests wait in idle until the result is registered. A 24x25 and a 25x26
// multiplier form each rounded filter update, first for the bias tracker, then the smoother.
// A result stall holds the last stage until the output register frees.
// Reset (i_rst_n low, synchronous): registers to defaults, state to zero.
module sway_velocity_estimator
    import sve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] accel_x, [63:32] time_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [47:0] sway_velocity
);

    t_cmd w_cmd;
    t_sts w_sts;

    sve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sve_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_data  (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- src/sve_checker.sv -----
module sve_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("new request taken while busy");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a request in progress");

endmodule

bind sway_velocity_estimator sve_checker u_sve_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
